>>> hw/rtl/assert_macros.svh
// assertion macros used by the rtl design
// no dependencies; synthesis builds see empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge out of reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: property does not hold");

// condition must never be seen out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed: forbidden condition seen");

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> hw/rtl/lwedb_pkg.sv
// types and constants for the lwe bit decryption stream
// no dependencies
package lwedb_pkg;

  // command codes
  localparam logic [1:0] CmdSecret = 2'd0;
  localparam logic [1:0] CmdCoeffU = 2'd1;
  localparam logic [1:0] CmdWordV  = 2'd2;

  // rounding offset of a quarter of the modulus and the sign bit position
  localparam logic [15:0] RoundOffset = 16'd16384;
  localparam int unsigned TopBit      = 15;

  // input request
  typedef struct packed {
    logic [1:0]  cmd;
    logic [6:0]  secret_index;
    logic [15:0] word;
  } in_req_t;

  // result
  typedef struct packed {
    logic       message_bit;
    logic [7:0] byte_value;
    logic       byte_ready;
  } out_res_t;

endpackage

>>> hw/rtl/lwe_decrypt_bit_stream.sv
// lwe bit decryption modulo 2^16 with byte packing
// depends on lwedb_pkg and assert_macros.svh

// Accepts one request per cycle. A request holding a secret word writes it to
// the secret store (writes at or above DIMENSION are dropped). A u coefficient
// reads the secret word at the running coefficient position when it is
// accepted; in the following cycle a 16 x 16 multiply adds the low half of the
// product into the wrapping accumulator. Coefficients past DIMENSION are
// dropped. A v word yields one result, registered once its request leaves the
// input stage: the top bit of (v - accumulator + 16384) mod 2^16,
// plus the completed byte (bits least significant first) on every eighth bit,
// else a zero byte value. The single secret store read port and the
// multiply-accumulate stage set the rate of one request per cycle; the input
// stalls only while a v request waits behind a result that is held off. The
// secret store has no reset and needs no clearing; reading a word that was
// never written gives an undefined result.
module lwe_decrypt_bit_stream #(
  parameter int unsigned DIMENSION = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lwedb_pkg::in_req_t in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lwedb_pkg::out_res_t out_res_o
);

  `include "assert_macros.svh"

  localparam int unsigned AW = (DIMENSION > 1) ? $clog2(DIMENSION) : 1;
  localparam int unsigned CW = $clog2(DIMENSION + 1);

  // secret store
  logic [15:0] secret_mem [DIMENSION];

  logic          in_accept;
  logic          wr_en;
  logic [31:0]   wr_index_ext;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          coeff_take;

  // coefficient position
  logic [CW-1:0] coef_pos_q, coef_pos_d;

  // input stage
  logic          s1_valid_q;
  logic [1:0]    s1_cmd_q;
  logic [15:0]   s1_word_q;
  logic          s1_take_q;
  logic [15:0]   s1_rdata_q;
  logic          s1_is_v;
  logic          s1_retire;

  // decryption state
  logic [15:0]   acc_q, acc_d;
  logic [2:0]    bit_pos_q, bit_pos_d;
  logic [7:0]    part_q, part_d;

  // datapath
  logic [15:0]   product;
  logic [15:0]   shifted;
  logic          dec_bit;
  logic [7:0]    assembled;
  logic          byte_done;

  // result register
  logic          out_valid_q, out_valid_d;
  lwedb_pkg::out_res_t out_q, out_d;

  // check helpers
  logic          v_retire;
  logic          v_blocked;
  logic          byte_out;
  logic          bit_only;

  // handshake
  assign s1_is_v    = (s1_cmd_q == lwedb_pkg::CmdWordV);
  assign s1_retire  = s1_valid_q && (!s1_is_v || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_retire;
  assign in_accept  = in_valid_i && !in_stall_o;

  // store addressing
  assign wr_index_ext = 32'(in_req_i.secret_index);
  assign wr_addr      = wr_index_ext[AW-1:0];
  assign wr_en        = in_accept && (in_req_i.cmd == lwedb_pkg::CmdSecret)
                        && (wr_index_ext < DIMENSION);
  assign rd_addr      = coef_pos_q[AW-1:0];
  assign coeff_take   = (in_req_i.cmd == lwedb_pkg::CmdCoeffU)
                        && (coef_pos_q < CW'(DIMENSION));

  // store write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      secret_mem[wr_addr] <= in_req_i.word;
    end
    if (in_accept) begin
      s1_rdata_q <= secret_mem[rd_addr];
      s1_cmd_q   <= in_req_i.cmd;
      s1_word_q  <= in_req_i.word;
      s1_take_q  <= coeff_take;
    end
  end

  // coefficient position tracks requests as they are accepted
  always_comb begin
    coef_pos_d = coef_pos_q;
    if (in_accept) begin
      if (coeff_take) begin
        coef_pos_d = coef_pos_q + CW'(1);
      end else if (in_req_i.cmd == lwedb_pkg::CmdWordV) begin
        coef_pos_d = '0;
      end
    end
  end

  // multiply-accumulate and decryption, low half of the product only
  assign product   = s1_word_q * s1_rdata_q;
  assign shifted   = s1_word_q - acc_q + lwedb_pkg::RoundOffset;
  assign dec_bit   = shifted[lwedb_pkg::TopBit];
  assign assembled = part_q | (8'(dec_bit) << bit_pos_q);
  assign byte_done = (bit_pos_q == 3'd7);

  always_comb begin
    acc_d       = acc_q;
    bit_pos_d   = bit_pos_q;
    part_d      = part_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (s1_retire) begin
      if (s1_cmd_q == lwedb_pkg::CmdCoeffU && s1_take_q) begin
        acc_d = acc_q + product;
      end else if (s1_is_v) begin
        acc_d                = '0;
        out_valid_d          = 1'b1;
        out_d.message_bit    = dec_bit;
        out_d.byte_ready     = byte_done;
        out_d.byte_value     = byte_done ? assembled : 8'd0;
        if (byte_done) begin
          part_d    = '0;
          bit_pos_d = '0;
        end else begin
          part_d    = assembled;
          bit_pos_d = bit_pos_q + 3'd1;
        end
      end
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_pos_q  <= '0;
      s1_valid_q  <= 1'b0;
      acc_q       <= '0;
      bit_pos_q   <= '0;
      part_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      coef_pos_q  <= coef_pos_d;
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_retire) begin
        s1_valid_q <= 1'b0;
      end
      acc_q       <= acc_d;
      bit_pos_q   <= bit_pos_d;
      part_q      <= part_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // terms used by the checks
  assign v_retire  = s1_retire && s1_is_v;
  assign v_blocked = s1_valid_q && s1_is_v && out_valid_q && out_stall_i;
  assign byte_out  = out_valid_o && out_res_o.byte_ready;
  assign bit_only  = out_valid_o && !out_res_o.byte_ready;

  // checks
  `ASSERT_NEVER(coef_pos_in_range, clk_i, rst_ni, coef_pos_q > CW'(DIMENSION))
  `ASSERT_HOLDS(byte_on_eighth_bit, clk_i, rst_ni, (v_retire && byte_done) |=> byte_out)
  `ASSERT_HOLDS(partial_byte_zero, clk_i, rst_ni, bit_only |-> (out_res_o.byte_value == 8'd0))
  `ASSERT_HOLDS(stall_only_on_blocked_v, clk_i, rst_ni, in_stall_o |-> v_blocked)

endmodule

>>> tb/tb_top.sv
// testbench for lwe_decrypt_bit_stream: directed, random and back-pressure tests
// depends on lwedb_pkg and the rtl top; predicts each decrypted bit and checks it in order
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KeyWords    = 128;
  localparam logic [1:0]  CmdIdle     = 2'd3;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles  = 300;

  // clock, reset and channel signals
  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  lwedb_pkg::in_req_t  in_req    = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  lwedb_pkg::out_res_t out_res;

  always #6 clk_i = ~clk_i;

  lwe_decrypt_bit_stream #(
    .DIMENSION (KeyWords)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_res_o   (out_res)
  );

  // decryptor state as predicted by the testbench
  logic [15:0] key_words [KeyWords];
  logic [15:0] dot_sum  = '0;
  int unsigned coef_pos = 0;
  logic [2:0]  bit_pos  = '0;
  logic [7:0]  byte_acc = '0;
  lwedb_pkg::out_res_t expected_bits [$];

  int unsigned mismatches    = 0;
  int unsigned reqs_accepted = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_on       = 1'b0;
  event        hold_off_go;

  // update the predicted state for one accepted request
  task automatic predict_decrypt(input lwedb_pkg::in_req_t r);
    logic [15:0] prod_lo;
    logic [15:0] rounded;
    logic        bit_val;
    logic [7:0]  assembled;
    lwedb_pkg::out_res_t res;
    case (r.cmd)
      lwedb_pkg::CmdSecret: begin
        key_words[r.secret_index] = r.word;
      end
      lwedb_pkg::CmdCoeffU: begin
        // coefficients past the key length are dropped
        if (coef_pos < KeyWords) begin
          prod_lo = r.word * key_words[coef_pos];
          dot_sum = dot_sum + prod_lo;
          coef_pos++;
        end
      end
      lwedb_pkg::CmdWordV: begin
        rounded   = r.word - dot_sum + lwedb_pkg::RoundOffset;
        bit_val   = rounded[lwedb_pkg::TopBit];
        assembled = byte_acc | (8'(bit_val) << bit_pos);
        res.message_bit = bit_val;
        res.byte_ready  = (bit_pos == 3'd7);
        res.byte_value  = res.byte_ready ? assembled : 8'd0;
        expected_bits.push_back(res);
        dot_sum  = '0;
        coef_pos = 0;
        byte_acc = res.byte_ready ? 8'd0 : assembled;
        bit_pos  = bit_pos + 3'd1;
      end
      default: ;
    endcase
  endtask

  // offer one request, with an optional gap first, and wait for acceptance
  task automatic send_req(input logic [1:0] cmd, input logic [6:0] idx,
                          input logic [15:0] word);
    lwedb_pkg::in_req_t r;
    r.cmd          = cmd;
    r.secret_index = idx;
    r.word         = word;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk_i); while (in_stall);
    predict_decrypt(r);
    reqs_accepted++;
  endtask

  // request that causes no result: unused command or key rewrite
  task automatic send_noise();
    if ($urandom_range(1) == 0) begin
      send_req(CmdIdle, 7'($urandom), 16'($urandom));
    end else begin
      send_req(lwedb_pkg::CmdSecret, 7'($urandom), 16'($urandom));
    end
  endtask

  // field extremes, rounding boundaries, unused command, one full byte
  task automatic test_directed_cases();
    send_req(lwedb_pkg::CmdSecret, 7'd0, 16'hFFFF);
    send_req(lwedb_pkg::CmdSecret, 7'd1, 16'h0001);
    send_req(lwedb_pkg::CmdSecret, 7'd127, 16'h8000);
    // ffff*ffff + ffff*0001 wraps the sum back to zero
    send_req(lwedb_pkg::CmdCoeffU, 7'h7F, 16'hFFFF);
    send_req(lwedb_pkg::CmdCoeffU, 7'h00, 16'hFFFF);
    send_req(lwedb_pkg::CmdWordV, 7'h00, 16'h0000);
    send_req(CmdIdle, 7'h7F, 16'hFFFF);
    // bits closed with no coefficients, v on either side of each boundary
    send_req(lwedb_pkg::CmdWordV, 7'h7F, 16'h3FFF);
    send_req(lwedb_pkg::CmdWordV, 7'h00, 16'h4000);
    send_req(lwedb_pkg::CmdWordV, 7'h00, 16'hBFFF);
    send_req(lwedb_pkg::CmdWordV, 7'h00, 16'hC000);
    send_req(lwedb_pkg::CmdWordV, 7'h00, 16'hFFFF);
    send_req(lwedb_pkg::CmdWordV, 7'h00, 16'h8000);
    // zero coefficient, eighth bit completes the byte
    send_req(lwedb_pkg::CmdCoeffU, 7'h00, 16'h0000);
    send_req(CmdIdle, 7'h00, 16'h0000);
    send_req(lwedb_pkg::CmdWordV, 7'h00, 16'hFFFF);
  endtask

  // write the whole key so that any coefficient position reads a written word
  task automatic test_key_load();
    for (int i = 0; i < KeyWords; i++) begin
      send_req(lwedb_pkg::CmdSecret, 7'(i), 16'($urandom));
    end
  endtask

  // random bit frames: coefficients then v, with noise mixed in
  task automatic test_random_frames(input int unsigned n_reqs);
    int unsigned stop_at;
    int unsigned n_coef;
    int unsigned pick;
    logic [15:0] v_word;
    stop_at = reqs_accepted + n_reqs;
    while (reqs_accepted < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_noise();
      end else begin
        pick = $urandom_range(99);
        if (pick < 2) begin
          n_coef = KeyWords;
        end else if (pick < 3) begin
          n_coef = $urandom_range(KeyWords + 12, KeyWords + 1);
        end else begin
          n_coef = $urandom_range(10, 0);
        end
        repeat (n_coef) begin
          if ($urandom_range(99) < 4) send_noise();
          send_req(lwedb_pkg::CmdCoeffU, 7'($urandom), 16'($urandom));
        end
        // a quarter of the v words land right at a rounding boundary
        if ($urandom_range(3) == 0) begin
          case ($urandom_range(3))
            0:       v_word = dot_sum + 16'h3FFF;
            1:       v_word = dot_sum + 16'h4000;
            2:       v_word = dot_sum + 16'hBFFF;
            default: v_word = dot_sum + 16'hC000;
          endcase
        end else begin
          v_word = 16'($urandom);
        end
        send_req(lwedb_pkg::CmdWordV, 7'($urandom), v_word);
      end
    end
  endtask

  // receiver holds off while short frames keep coming, so the block backs up
  task automatic test_output_hold();
    -> hold_off_go;
    repeat (48) begin
      send_req(lwedb_pkg::CmdCoeffU, 7'($urandom), 16'($urandom));
      send_req(lwedb_pkg::CmdWordV, 7'($urandom), 16'($urandom));
    end
  endtask

  // long receiver hold-off, counted here
  initial begin
    forever begin
      @(hold_off_go);
      hold_on <= 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      hold_on <= 1'b0;
    end
  end

  // result check against the oldest expectation, then the next stall value
  always @(posedge clk_i) begin : result_check
    lwedb_pkg::out_res_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_bits.size() == 0) begin
        $error("result with nothing expected: %h", out_res);
        mismatches++;
      end else begin
        want = expected_bits.pop_front();
        if (out_res.message_bit !== want.message_bit) begin
          $error("message_bit: expected %0d, got %0d", want.message_bit, out_res.message_bit);
          mismatches++;
        end
        if (out_res.byte_value !== want.byte_value) begin
          $error("byte_value: expected %0h, got %0h", want.byte_value, out_res.byte_value);
          mismatches++;
        end
        if (out_res.byte_ready !== want.byte_ready) begin
          $error("byte_ready: expected %0d, got %0d", want.byte_ready, out_res.byte_ready);
          mismatches++;
        end
      end
    end
    out_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    send_idle_pct = 19;
    recv_idle_pct = 69;
    test_key_load();
    test_random_frames(420);
    send_idle_pct = 69;
    recv_idle_pct = 19;
    test_random_frames(420);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(420);
    test_output_hold();
    in_valid <= 1'b0;
    while (expected_bits.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
